// ===== src/spd_pkg.sv =====
// Shared types and constants for the spike peak detector.
// No dependencies; used by spd_ring and spike_peak_detector_unit.
package spd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 16;
  localparam int WIN_W      = 9;
  localparam int REC_W      = 17;
  localparam int RING_AW    = 8;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int MAX_RECORD = 65536;
  localparam int WINDOW_MAX = 256;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = REC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EV   = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SEARCH = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  typedef struct packed {
    logic                       we;
    logic [RING_AW-1:0]         waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic                       re;
    logic [RING_AW-1:0]         raddr;
  } ring_req_t;

endpackage

// ===== src/spd_ring.sv =====
// Sample ring of the spike peak detector: one write port, one registered read port.
// Depends on spd_pkg.
module spd_ring import spd_pkg::*; (
  input  logic                       clk,
  input  ring_req_t                  req,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/spike_peak_detector_unit.sv =====
// Top level of the spike peak detector: scan control, peak search and result register.
// Depends on spd_pkg and spd_ring.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | in_tdata[15:0] sample
//  out_    | output    | out_tvalid/out_tready | out_tdata spike_index, peak_amplitude
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A plain item passes through the accept state (ST_IDLE) and then the evaluation state (ST_EV).
// After a peak search ends, each sample replayed from the peak up to the newest one
// passes through a ring read (ST_RD), then an evaluation (ST_EV), using the single ring read port.
// Reset is synchronous; the ring needs no clearing since unwritten entries are never read.
// Evaluation of a reportable peak waits while the output register holds an item that out_tready does not take.
module spike_peak_detector_unit import spd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,    // [15:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,   // [15:0] spike_index, [31:16] peak_amplitude
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t                     state_r, state_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [IDX_W-1:0]           n_r, n_nxt;
  logic [IDX_W-1:0]           p_r, p_nxt;
  logic [IDX_W-1:0]           cross_r, cross_nxt;
  logic [IDX_W-1:0]           best_idx_r, best_idx_nxt;
  logic signed [SAMPLE_W-1:0] best_val_r, best_val_nxt;
  logic                       count_r, count_nxt;
  logic                       sel_in_r, sel_in_nxt;
  logic signed [SAMPLE_W-1:0] hold_r, hold_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]           out_idx_r, out_idx_nxt;
  logic signed [SAMPLE_W-1:0] out_amp_r, out_amp_nxt;
  logic signed [SAMPLE_W-1:0] thr_r, thr_nxt;
  logic [WIN_W-1:0]           win_r, win_nxt;
  logic [REC_W-1:0]           rec_r, rec_nxt;

  ring_req_t                  ring_req;
  logic signed [SAMPLE_W-1:0] ring_rdata;
  logic signed [SAMPLE_W-1:0] v;
  logic [REC_W-1:0]           len;
  logic [IDX_W-1:0]           last;
  logic [WIN_W-1:0]           w;
  logic [WIN_W-1:0]           span;
  logic                       in_acc;

  phase_t                     ev_phase;
  logic [IDX_W-1:0]           ev_cross;
  logic [IDX_W-1:0]           ev_best_idx;
  logic signed [SAMPLE_W-1:0] ev_best_val;
  logic                       finish;
  logic                       report;
  logic                       stall;
  logic                       step_done;
  logic                       rec_end;

  spd_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_amp_r, out_idx_r};

  always_comb begin
    ring_req.we    = in_acc;
    ring_req.waddr = n_r[RING_AW-1:0];
    ring_req.wdata = in_tdata;
    ring_req.re    = (state_r == ST_RD);
    ring_req.raddr = p_r[RING_AW-1:0];
  end

  assign v = sel_in_r ? hold_r : ring_rdata;

  always_comb begin
    if (rec_r == '0) begin
      len = REC_W'(1);
    end else if (rec_r > REC_W'(MAX_RECORD)) begin
      len = REC_W'(MAX_RECORD);
    end else begin
      len = rec_r;
    end
    last = IDX_W'(len - REC_W'(1));
    w    = (win_r > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : win_r;
    span = (w == '0) ? WIN_W'(1) : w;
  end

  always_comb begin
    ev_phase    = phase_r;
    ev_cross    = cross_r;
    ev_best_idx = best_idx_r;
    ev_best_val = best_val_r;
    finish      = 1'b0;
    case (phase_r)
      PH_SEARCH: begin
        if (v > best_val_r) begin
          ev_best_val = v;
          ev_best_idx = p_r;
        end
        finish = ({1'b0, p_r} - {1'b0, cross_r} + REC_W'(1) >= REC_W'(span))
                 || (p_r >= last);
      end
      PH_SKIP: begin
        if (v <= thr_r) begin
          ev_phase = PH_IDLE;
        end
      end
      default: begin
        ev_phase = PH_IDLE;
        if (v > thr_r) begin
          ev_phase    = PH_SEARCH;
          ev_cross    = p_r;
          ev_best_idx = p_r;
          ev_best_val = v;
          finish      = (span <= WIN_W'(1)) || (p_r >= last);
        end
      end
    endcase
    if (finish) begin
      ev_phase = PH_SKIP;
    end
    report    = finish && (ev_best_idx > IDX_W'(w))
                && ({1'b0, ev_best_idx} + REC_W'(w) < len) && !count_r;
    stall     = report && out_valid_r && !out_tready;
    step_done = !finish && (p_r == n_r);
    rec_end   = (n_r >= last) || ({1'b0, n_r} + REC_W'(1) >= REC_W'(MAX_RECORD));
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    cross_nxt     = cross_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    count_nxt     = count_r;
    sel_in_nxt    = sel_in_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_amp_nxt   = out_amp_r;
    thr_nxt       = thr_r;
    win_nxt       = win_r;
    rec_nxt       = rec_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_nxt = cfg_data[SAMPLE_W-1:0];
        CFG_WINDOW:    win_nxt = cfg_data[WIN_W-1:0];
        CFG_RECORD:    rec_nxt = cfg_data;
        default:       ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hold_nxt   = in_tdata;
          sel_in_nxt = 1'b1;
          p_nxt      = n_r;
          count_nxt  = 1'b0;
          state_nxt  = ST_EV;
        end
      end
      ST_RD: begin
        sel_in_nxt = 1'b0;
        state_nxt  = ST_EV;
      end
      ST_EV: begin
        if (!stall) begin
          phase_nxt    = ev_phase;
          cross_nxt    = ev_cross;
          best_idx_nxt = ev_best_idx;
          best_val_nxt = ev_best_val;
          if (report) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = ev_best_idx;
            out_amp_nxt   = ev_best_val;
            count_nxt     = 1'b1;
          end
          p_nxt = finish ? ev_best_idx : p_r + IDX_W'(1);
          if (step_done) begin
            state_nxt = ST_IDLE;
            if (rec_end) begin
              n_nxt     = '0;
              phase_nxt = PH_IDLE;
            end else begin
              n_nxt = n_r + IDX_W'(1);
            end
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      n_r         <= '0;
      cross_r     <= '0;
      best_idx_r  <= '0;
      best_val_r  <= '0;
      count_r     <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= '0;
      win_r       <= WIN_W'(32);
      rec_r       <= REC_W'(MAX_RECORD);
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      n_r         <= n_nxt;
      cross_r     <= cross_nxt;
      best_idx_r  <= best_idx_nxt;
      best_val_r  <= best_val_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      win_r       <= win_nxt;
      rec_r       <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    sel_in_r  <= sel_in_nxt;
    hold_r    <= hold_nxt;
    out_idx_r <= out_idx_nxt;
    out_amp_r <= out_amp_nxt;
  end

`ifndef SYNTH
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EV) && sel_in_r)
    else $error("accepted item did not go to evaluation");

  a_read_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |=> (state_r == ST_EV) && !sel_in_r)
    else $error("ring read not followed by evaluation");

  a_replay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RD) || (state_r == ST_EV)) |-> (p_r <= n_r))
    else $error("replay position beyond newest sample");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEARCH) |-> (cross_r <= best_idx_r))
    else $error("peak index before crossing index");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EV) && count_r) |-> !report)
    else $error("second result for one item");
`endif

endmodule
